// ===== rtl/rsa_key_derivation_core_assert.svh =====
// Assertion helpers shared by the key derivation core.
`ifndef RSA_KEY_DERIVATION_CORE_ASSERT_SVH
`define RSA_KEY_DERIVATION_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RKD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define RKD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/rkd_pkg.sv =====
package rkd_pkg;

  // Status codes of a result transaction
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_P_BAD = 2'd1;
  localparam logic [1:0] ST_Q_BAD = 2'd2;
  localparam logic [1:0] ST_EQUAL = 2'd3;

  // Trial division walks 6k-1 / 6k+1
  localparam logic [16:0] TRIAL_FIRST = 17'd5;
  localparam logic [16:0] TRIAL_PAIR  = 17'd2;
  localparam logic [16:0] TRIAL_STEP  = 17'd6;

  // Public exponent search
  localparam logic [15:0] E_FIRST = 16'd3;
  localparam logic [15:0] E_STEP  = 16'd2;
  localparam logic [15:0] E_LIMIT = 16'd65533;

  // Depth of the queue between front and back
  localparam int Q_DEPTH = 2;

  localparam int DIV_W = 64;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quo;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;

endpackage

// ===== rtl/rkd_if.sv =====
interface rkd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] p_candidate;
  logic [31:0] q_candidate;

  modport source (output valid, output p_candidate, output q_candidate, input ready);
  modport sink (input valid, input p_candidate, input q_candidate, output ready);
endinterface

interface rkd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] modulus;
  logic [15:0] public_exponent;
  logic [63:0] private_exponent;

  modport source (output valid, output status, output modulus, output public_exponent,
                  output private_exponent, input ready);
  modport sink (input valid, input status, input modulus, input public_exponent,
                input private_exponent, output ready);
endinterface

// ===== rtl/rkd_front.sv =====
module rkd_front
  import rkd_pkg::*;
#(
  parameter int PRIME_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rkd_in_if.sink                in_ch,
  input  logic                  pop,
  output logic                  head_valid,
  output logic [PRIME_BITS-1:0] head_p,
  output logic [PRIME_BITS-1:0] head_q
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  logic [PRIME_BITS-1:0] qp_r [Q_DEPTH];
  logic [PRIME_BITS-1:0] qq_r [Q_DEPTH];
  logic [PTR_W-1:0]      wr_ptr_r;
  logic [PTR_W-1:0]      rd_ptr_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  push;
  logic                  take;

  assign in_ch.ready = (cnt_r != CNT_W'(Q_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign head_valid  = (cnt_r != '0);
  assign take        = pop && head_valid;
  assign head_p      = qp_r[rd_ptr_r];
  assign head_q      = qq_r[rd_ptr_r];

  // Store the masked candidates of an accepted transaction
  always_ff @(posedge clk) begin
    if (push) begin
      qp_r[wr_ptr_r] <= in_ch.p_candidate[PRIME_BITS-1:0];
      qq_r[wr_ptr_r] <= in_ch.q_candidate[PRIME_BITS-1:0];
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (take) rd_ptr_r <= (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !take) cnt_r <= cnt_r + 1'b1;
      else if (take && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ===== rtl/rkd_div.sv =====
module rkd_div
  import rkd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_W-1:0]         quo_r;
  logic [DIV_W-1:0]         rem_r;
  logic [DIV_W-1:0]         dvs_r;
  logic [$clog2(DIV_W)-1:0] cnt_r;
  logic                     busy_r;
  logic                     done_r;
  logic [DIV_W:0]           trial;
  logic [DIV_W:0]           diff;
  logic                     ge;

  // One restoring step per cycle
  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = (trial >= {1'b0, dvs_r});

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == '1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end
    end
  end

  // Shift quotient bits in as the dividend shifts out
  always_ff @(posedge clk) begin
    if (busy_r) begin
      rem_r <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], ge};
    end else if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
    end
  end

endmodule

// ===== rtl/rkd_back.sv =====
module rkd_back
  import rkd_pkg::*;
#(
  parameter int PRIME_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  head_valid,
  input  logic [PRIME_BITS-1:0] head_p,
  input  logic [PRIME_BITS-1:0] head_q,
  output logic                  pop,
  output div_req_t              div_req,
  input  div_rsp_t              div_rsp,
  rkd_out_if.source             out_ch
);

`include "rsa_key_derivation_core_assert.svh"

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_PT   = 5'd1;
  localparam logic [4:0] S_M2   = 5'd2;
  localparam logic [4:0] S_M3   = 5'd3;
  localparam logic [4:0] S_SQ   = 5'd4;
  localparam logic [4:0] S_CMP  = 5'd5;
  localparam logic [4:0] S_MA   = 5'd6;
  localparam logic [4:0] S_MB   = 5'd7;
  localparam logic [4:0] S_EQ   = 5'd8;
  localparam logic [4:0] S_MN   = 5'd9;
  localparam logic [4:0] S_MP   = 5'd10;
  localparam logic [4:0] S_G0   = 5'd11;
  localparam logic [4:0] S_G1   = 5'd12;
  localparam logic [4:0] S_G2   = 5'd13;
  localparam logic [4:0] S_IV0  = 5'd14;
  localparam logic [4:0] S_IV1  = 5'd15;
  localparam logic [4:0] S_IV2  = 5'd16;
  localparam logic [4:0] S_IV3  = 5'd17;
  localparam logic [4:0] S_IV4  = 5'd18;
  localparam logic [4:0] S_IV5  = 5'd19;
  localparam logic [4:0] S_IV6  = 5'd20;
  localparam logic [4:0] S_IV7  = 5'd21;
  localparam logic [4:0] S_OUT  = 5'd22;

  logic [4:0]  state_r;
  logic [31:0] p_r, q_r;
  logic        cur_r;
  logic [16:0] dv_r;
  logic [33:0] sq_r;
  logic [63:0] n_r, phi_r, ga_r, gb_r, a_r, d_r;
  logic [15:0] e_r, r_r;
  logic [16:0] k_r;
  logic [31:0] t_r, qt_r;
  logic [47:0] plo_r, phh_r;
  logic [1:0]  status_r;
  logic        dstart_r;
  logic [63:0] ddvd_r, ddvs_r;
  logic        out_valid_r;
  logic [1:0]  o_status_r;
  logic [63:0] o_n_r, o_d_r;
  logic [15:0] o_e_r;
  logic [31:0] nv;
  logic        fail_status_q;
  logic        nv_div3;
  logic        out_fail_zero;
  logic        out_e_ok;

  // Divisibility by 3: fold base-4 digits, since 4 is 1 modulo 3
  function automatic logic div3_check(input logic [31:0] v);
    logic [5:0] s1;
    logic [3:0] s2;
    logic [2:0] s3;
    s1 = '0;
    for (int i = 0; i < 16; i++) s1 = s1 + 6'(v[2*i +: 2]);
    s2 = 4'(s1[5:4]) + 4'(s1[3:2]) + 4'(s1[1:0]);
    s3 = 3'(s2[3:2]) + 3'(s2[1:0]);
    return (s3 == 3'd0) || (s3 == 3'd3);
  endfunction

  assign nv            = cur_r ? q_r : p_r;
  assign nv_div3       = div3_check(nv);
  assign fail_status_q = cur_r;
  assign pop           = (state_r == S_IDLE) && head_valid;

  assign div_req.start    = dstart_r;
  assign div_req.dividend = ddvd_r;
  assign div_req.divisor  = ddvs_r;

  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = o_status_r;
  assign out_ch.modulus          = o_n_r;
  assign out_ch.public_exponent  = o_e_r;
  assign out_ch.private_exponent = o_d_r;

  assign out_fail_zero = (o_n_r == 64'd0) && (o_d_r == 64'd0) && (o_e_r == 16'd0);
  assign out_e_ok      = o_e_r[0] && (o_e_r >= E_FIRST);

  // Control: sequencer state, divider start pulse, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dstart_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      dstart_r <= 1'b0;
      if (out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (head_valid) state_r <= S_PT;
        S_PT: begin
          if (nv <= 32'd3) begin
            if (!nv[1]) state_r <= S_OUT;
            else state_r <= cur_r ? S_EQ : S_PT;
          end else begin
            state_r <= S_M2;
          end
        end
        S_M2: state_r <= nv[0] ? S_M3 : S_OUT;
        S_M3: state_r <= nv_div3 ? S_OUT : S_SQ;
        S_SQ: state_r <= S_CMP;
        S_CMP: begin
          if (sq_r > 34'(nv)) state_r <= cur_r ? S_EQ : S_PT;
          else begin
            dstart_r <= 1'b1;
            state_r  <= S_MA;
          end
        end
        S_MA: if (div_rsp.done) begin
          if (div_rsp.rem == '0) state_r <= S_OUT;
          else begin
            dstart_r <= 1'b1;
            state_r  <= S_MB;
          end
        end
        S_MB: if (div_rsp.done) state_r <= (div_rsp.rem == '0) ? S_OUT : S_SQ;
        S_EQ: state_r <= (p_r == q_r) ? S_OUT : S_MN;
        S_MN: state_r <= S_MP;
        S_MP: state_r <= S_G0;
        S_G0: state_r <= S_G1;
        S_G1: begin
          if (gb_r == '0) begin
            state_r <= (ga_r == 64'd1 || e_r >= E_LIMIT) ? S_IV0 : S_G0;
          end else begin
            dstart_r <= 1'b1;
            state_r  <= S_G2;
          end
        end
        S_G2: if (div_rsp.done) state_r <= S_G1;
        S_IV0: begin
          if (phi_r <= 64'd1 || e_r < 16'd2) state_r <= S_OUT;
          else begin
            dstart_r <= 1'b1;
            state_r  <= S_IV1;
          end
        end
        S_IV1: if (div_rsp.done) state_r <= S_IV2;
        S_IV2: state_r <= (k_r >= 17'(e_r)) ? S_OUT : S_IV3;
        S_IV3: begin
          dstart_r <= 1'b1;
          state_r  <= S_IV4;
        end
        S_IV4: if (div_rsp.done) state_r <= (div_rsp.rem == '0) ? S_IV5 : S_IV2;
        S_IV5: state_r <= S_IV6;
        S_IV6: state_r <= S_IV7;
        S_IV7: state_r <= S_OUT;
        S_OUT: if (!out_valid_r || out_ch.ready) begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: if (head_valid) begin
        p_r      <= 32'(head_p);
        q_r      <= 32'(head_q);
        cur_r    <= 1'b0;
        status_r <= ST_OK;
        n_r      <= '0;
        e_r      <= '0;
        d_r      <= '0;
      end
      S_PT: begin
        if (nv <= 32'd3) begin
          if (!nv[1]) status_r <= fail_status_q ? ST_Q_BAD : ST_P_BAD;
          else cur_r <= 1'b1;
        end else begin
          ddvd_r <= 64'(nv);
        end
      end
      S_M2: if (!nv[0]) status_r <= fail_status_q ? ST_Q_BAD : ST_P_BAD;
      S_M3: begin
        if (nv_div3) status_r <= fail_status_q ? ST_Q_BAD : ST_P_BAD;
        dv_r <= TRIAL_FIRST;
      end
      S_SQ: sq_r <= 34'(dv_r) * 34'(dv_r);
      S_CMP: begin
        if (sq_r > 34'(nv)) cur_r <= 1'b1;
        else ddvs_r <= 64'(dv_r);
      end
      S_MA: if (div_rsp.done) begin
        if (div_rsp.rem == '0) status_r <= fail_status_q ? ST_Q_BAD : ST_P_BAD;
        else ddvs_r <= 64'(dv_r + TRIAL_PAIR);
      end
      S_MB: if (div_rsp.done) begin
        if (div_rsp.rem == '0) status_r <= fail_status_q ? ST_Q_BAD : ST_P_BAD;
        dv_r <= dv_r + TRIAL_STEP;
      end
      S_EQ: if (p_r == q_r) status_r <= ST_EQUAL;
      S_MN: n_r <= 64'(p_r) * 64'(q_r);
      S_MP: begin
        phi_r <= 64'(p_r - 32'd1) * 64'(q_r - 32'd1);
        e_r   <= E_FIRST;
      end
      S_G0: begin
        ga_r <= 64'(e_r);
        gb_r <= phi_r;
      end
      S_G1: begin
        if (gb_r == '0) begin
          if (!(ga_r == 64'd1 || e_r >= E_LIMIT)) e_r <= e_r + E_STEP;
        end else begin
          ddvd_r <= ga_r;
          ddvs_r <= gb_r;
        end
      end
      S_G2: if (div_rsp.done) begin
        ga_r <= gb_r;
        gb_r <= div_rsp.rem;
      end
      S_IV0: begin
        ddvd_r <= phi_r;
        ddvs_r <= 64'(e_r);
      end
      S_IV1: if (div_rsp.done) begin
        a_r <= div_rsp.quo;
        r_r <= div_rsp.rem[15:0];
        k_r <= '0;
      end
      S_IV2: t_r <= 32'(k_r[15:0]) * 32'(r_r) + 32'd1;
      S_IV3: begin
        ddvd_r <= 64'(t_r);
        ddvs_r <= 64'(e_r);
      end
      S_IV4: if (div_rsp.done) begin
        if (div_rsp.rem == '0) qt_r <= div_rsp.quo[31:0];
        else k_r <= k_r + 17'd1;
      end
      S_IV5: plo_r <= 48'(k_r[15:0]) * 48'(a_r[31:0]);
      S_IV6: phh_r <= 48'(k_r[15:0]) * 48'(a_r[63:32]);
      S_IV7: d_r <= 64'(plo_r) + {phh_r[31:0], 32'd0} + 64'(qt_r);
      S_OUT: if (!out_valid_r || out_ch.ready) begin
        o_status_r <= status_r;
        o_n_r      <= (status_r == ST_OK) ? n_r : '0;
        o_e_r      <= (status_r == ST_OK) ? e_r : '0;
        o_d_r      <= (status_r == ST_OK) ? d_r : '0;
      end
      default: ;
    endcase
  end

  `RKD_ASSERT_IMPLY(a_fail_zero, clk, rst_n, out_ch.valid && out_ch.status != ST_OK, out_fail_zero)
  `RKD_ASSERT_IMPLY(a_ok_exp_odd, clk, rst_n, out_ch.valid && out_ch.status == ST_OK, out_e_ok)
  `RKD_ASSERT_IMPLY(a_div_free, clk, rst_n, div_req.start, !div_rsp.busy)
  `RKD_ASSERT_NEXT(a_pop_leaves_idle, clk, rst_n, pop, state_r == S_PT)

endmodule

// ===== rtl/rsa_key_derivation_core.sv =====
// Derives a textbook key pair from two candidate primes. Each transaction
// yields one result: a status (ok, first or second not prime, equal), and
// on success the modulus p*q, the smallest odd public exponent from 3 that
// is coprime to (p-1)(q-1), and its inverse modulo that totient; on failure
// the numeric fields are zero. Only the low PRIME_BITS bits of each candidate
// are used. The tests by 2 and 3 need no divider; every other division
// goes through one shared bit-serial divider, which sets the latency:
// two divisions per trial divisor pair up to the square root of each
// candidate, plus one per Euclid step and one per inverse candidate. One
// transaction is worked at a time; a two-entry input queue and an output
// register let both sides stall freely.
module rsa_key_derivation_core
  import rkd_pkg::*;
#(
  parameter int PRIME_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  rkd_in_if.sink    in_ch,
  rkd_out_if.source out_ch
);

  logic                  pop;
  logic                  head_valid;
  logic [PRIME_BITS-1:0] head_p;
  logic [PRIME_BITS-1:0] head_q;
  div_req_t              div_req;
  div_rsp_t              div_rsp;

  rkd_front #(.PRIME_BITS(PRIME_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .pop        (pop),
    .head_valid (head_valid),
    .head_p     (head_p),
    .head_q     (head_q)
  );

  rkd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  rkd_back #(.PRIME_BITS(PRIME_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_p     (head_p),
    .head_q     (head_q),
    .pop        (pop),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .out_ch     (out_ch)
  );

endmodule

// ===== tb/rkd_checker.sv =====
module rkd_checker
  import rkd_pkg::*;
#(
  parameter int PRIME_BITS = 32
) (
  input  logic clk,
  input  logic rst_n,
  rkd_in_if    in_mon,
  rkd_out_if   out_mon,
  output int   fail_count,
  output int   key_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] modulus;
    logic [15:0] public_exponent;
    logic [63:0] private_exponent;
  } key_result_t;

  key_result_t expected_keys[$];
  int          results_seen;

  // Trial division by 2, 3, then 6k-1 / 6k+1 up to the square root
  function automatic bit prime_check(longint unsigned n);
    longint unsigned dv;
    if (n <= 3) return n > 1;
    if (n % 2 == 0 || n % 3 == 0) return 0;
    for (dv = 5; dv * dv <= n; dv += 6)
      if (n % dv == 0 || n % (dv + 2) == 0) return 0;
    return 1;
  endfunction

  function automatic longint unsigned euclid_gcd(longint unsigned a, longint unsigned b);
    longint unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // Inverse of a small exponent, split as phi = a*e + r to stay in 64 bits
  function automatic longint unsigned small_inverse(longint unsigned e, longint unsigned phi);
    longint unsigned a, r, k;
    if (phi <= 1 || e < 2) return 0;
    a = phi / e;
    r = phi % e;
    for (k = 0; k < e; k++)
      if ((k * r + 1) % e == 0) return k * a + (k * r + 1) / e;
    return 0;
  endfunction

  function automatic key_result_t derive_key(logic [31:0] p_in, logic [31:0] q_in);
    key_result_t     res;
    longint unsigned mask, p, q, phi, e;
    mask = (64'd1 << PRIME_BITS) - 1;
    p = p_in & mask;
    q = q_in & mask;
    res = '0;
    if (!prime_check(p)) begin
      res.status = ST_P_BAD;
    end else if (!prime_check(q)) begin
      res.status = ST_Q_BAD;
    end else if (p == q) begin
      res.status = ST_EQUAL;
    end else begin
      res.status = ST_OK;
      phi = (p - 1) * (q - 1);
      res.modulus = p * q;
      e = E_FIRST;
      while (euclid_gcd(e, phi) != 1 && e < E_LIMIT) e += E_STEP;
      res.public_exponent = e[15:0];
      res.private_exponent = small_inverse(e, phi);
    end
    return res;
  endfunction

  assign key_count = results_seen;

  // Predict on each input transaction, compare on each result transaction
  always @(posedge clk) begin
    key_result_t want;
    int          errs;
    errs = 0;
    if (!rst_n) begin
      fail_count <= 0;
      results_seen <= 0;
      pending <= 0;
      expected_keys.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        expected_keys.push_back(derive_key(in_mon.p_candidate, in_mon.q_candidate));
      if (out_mon.valid && out_mon.ready) begin
        results_seen <= results_seen + 1;
        if (expected_keys.size() == 0) begin
          $error("result with no transaction pending: status %0d", out_mon.status);
          errs = errs + 1;
        end else begin
          want = expected_keys.pop_front();
          if (out_mon.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_mon.status);
            errs = errs + 1;
          end
          if (out_mon.modulus !== want.modulus) begin
            $error("modulus: expected %0d, got %0d", want.modulus, out_mon.modulus);
            errs = errs + 1;
          end
          if (out_mon.public_exponent !== want.public_exponent) begin
            $error("public_exponent: expected %0d, got %0d",
                   want.public_exponent, out_mon.public_exponent);
            errs = errs + 1;
          end
          if (out_mon.private_exponent !== want.private_exponent) begin
            $error("private_exponent: expected %0d, got %0d",
                   want.private_exponent, out_mon.private_exponent);
            errs = errs + 1;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending <= expected_keys.size();
    end
  end
endmodule

// ===== tb/tb_rsa_key_derivation_core.sv =====
module tb_rsa_key_derivation_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          SIEVE_TOP   = 16384;
  localparam int          RAND_ITEMS  = 80;
  localparam longint      CYCLE_LIMIT = 40_000_000;
  localparam logic [31:0] BIG_PRIME   = 32'd4294967291;

  logic clk = 0;
  logic rst_n = 0;
  int   fail_count, key_count, pending;
  longint cycles = 0;
  int   sent = 0;
  bit   calm = 0;
  bit   composite[SIEVE_TOP];
  int unsigned primes[$];

  rkd_in_if  in_ch();
  rkd_out_if out_ch();

  rsa_key_derivation_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rkd_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .key_count  (key_count),
    .pending    (pending)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("rsa_key_derivation_core: mismatch");
      $finish;
    end
  end

  // Stall the result side at random, except in calm stretches
  initial out_ch.ready = 0;
  always @(negedge clk)
    out_ch.ready <= calm || ($urandom_range(0, 99) >= 22);

  // Offer one transaction, holding valid high until it is taken
  task automatic send_pair(logic [31:0] p, logic [31:0] q);
    while (!calm && $urandom_range(0, 99) < 22) begin
      in_ch.valid <= 0;
      @(negedge clk);
    end
    in_ch.valid <= 1;
    in_ch.p_candidate <= p;
    in_ch.q_candidate <= q;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  function automatic int unsigned pick_prime();
    return primes[$urandom_range(0, primes.size() - 1)];
  endfunction

  // Random value with a factor of 3, so it fails fast as a candidate
  function automatic logic [31:0] noise_value();
    logic [31:0] v;
    v = $urandom;
    return v - (v % 3);
  endfunction

  initial begin
    int unsigned p, q;
    int          kind;
    in_ch.valid = 0;
    in_ch.p_candidate = 0;
    in_ch.q_candidate = 0;

    // Build a prime list for well-formed pairs
    for (int i = 2; i < SIEVE_TOP; i++)
      if (!composite[i]) begin
        primes.push_back(i);
        for (int j = i * i; j < SIEVE_TOP; j += i) composite[j] = 1;
      end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: small values, squares, equal pairs, extremes
    send_pair(0, 5);
    send_pair(1, 7);
    send_pair(4, 7);
    send_pair(25, 7);
    send_pair(5, 49);
    send_pair(7, 121);
    send_pair(5, 0);
    send_pair(5, 1);
    send_pair(2, 2);
    send_pair(13, 13);
    send_pair(2, 3);
    send_pair(3, 2);
    send_pair(3, 5);
    send_pair(7, 11);
    send_pair(11, 31);
    send_pair(32'hFFFF_FFFF, 5);
    send_pair(5, 32'hFFFF_FFFF);
    send_pair(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_pair(65521, 65519);
    send_pair(BIG_PRIME, 65521);
    send_pair(65521, 4);

    // Random: mostly distinct prime pairs, some equal pairs and noise
    for (int n = 0; n < RAND_ITEMS; n++) begin
      calm = (n >= 40 && n < 60);
      kind = $urandom_range(0, 99);
      p = pick_prime();
      q = pick_prime();
      if (kind < 10) q = p;
      else if (kind < 20) p = noise_value();
      else if (kind < 30) q = noise_value();
      else if (kind < 35) begin
        p = noise_value();
        q = noise_value();
      end
      send_pair(p, q);
    end
    calm = 0;
    in_ch.valid <= 0;

    // Drain outstanding results
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("sent %0d candidate pairs, checked %0d results in %0d cycles",
             sent, key_count, cycles);
    if (fail_count == 0 && pending == 0)
      $display("rsa_key_derivation_core: match");
    else
      $display("rsa_key_derivation_core: mismatch");
    $finish;
  end
endmodule
